/* sv/linear_probe_hash_map_macros.svh */
// Assertion macros used by the hash map RTL.
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LPH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LPH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lph_pkg.sv */
// Shared constants for the linear probing hash map.
`timescale 1ns / 1ps

package lph_pkg;

    localparam int KEY_PORT_W    = 64;
    localparam int HASH_PORT_W   = 32;
    localparam int VALUE_PORT_W  = 64;
    localparam int STATUS_W      = 3;
    localparam int CFG_W         = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [31:0] LOAD_SCALE = 32'd100;

endpackage

/* sv/lph_req_if.sv */
// Request channel interface of the hash map.
`timescale 1ns / 1ps

interface lph_req_if
    import lph_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [KEY_PORT_W-1:0]   key;
    logic [HASH_PORT_W-1:0]  key_hash;
    logic [VALUE_PORT_W-1:0] put_value;

    modport source (output valid, req_type, key, key_hash, put_value, input ready);
    modport sink   (input valid, req_type, key, key_hash, put_value, output ready);
endinterface

/* sv/lph_rsp_if.sv */
// Response channel interface of the hash map.
`timescale 1ns / 1ps

interface lph_rsp_if
    import lph_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [VALUE_PORT_W-1:0] read_value;

    modport source (output valid, status, read_value, input ready);
    modport sink   (input valid, status, read_value, output ready);
endinterface

/* sv/linear_probe_hash_map.sv */
// Top level of the linear probing key/value hash map.
`timescale 1ns / 1ps

// An item is accepted only when the block is idle, and each probe is one read of the slot RAM.
// After reset and after a write of the capacity register the active bank is cleared slot by
// slot, and no word is accepted meanwhile. An insert that pushes the load past the limit starts
// a rehash into the other bank: it clears that bank, then reads each old slot and moves every
// valid entry, probing the new bank for a free slot; its result word is already presented.

module linear_probe_hash_map
    import lph_pkg::*;
#(
    parameter int MAX_CAPACITY_LOG2   = 10,
    parameter int MIN_CAPACITY        = 8,
    parameter int LOAD_FACTOR_PERCENT = 75,
    parameter int KEY_WIDTH           = 64,
    parameter int VALUE_WIDTH         = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    lph_req_if.sink          req,
    lph_rsp_if.source        rsp
);

`include "linear_probe_hash_map_macros.svh"

    localparam int IW     = MAX_CAPACITY_LOG2;
    localparam int HW     = MAX_CAPACITY_LOG2;
    localparam int LW     = $clog2(MAX_CAPACITY_LOG2 + 1);
    localparam int EW     = 1 + HW + KEY_WIDTH + VALUE_WIDTH;
    localparam int MIN_LG = $clog2(MIN_CAPACITY);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_GCLR  = 4'd3;
    localparam logic [3:0] S_GRD   = 4'd4;
    localparam logic [3:0] S_GCHK  = 4'd5;
    localparam logic [3:0] S_GPRB  = 4'd6;

    function automatic logic [LW-1:0] start_lg(input logic [CFG_W-1:0] v);
        int unsigned lg;
        lg = 32'(v);
        if (lg < MIN_LG)
        begin
            lg = MIN_LG;
        end
        if (lg > MAX_CAPACITY_LOG2)
        begin
            lg = MAX_CAPACITY_LOG2;
        end
        return LW'(lg);
    endfunction

    logic [3:0]             state_reg, state_next;
    logic                   act_reg, act_next;
    logic [CFG_W-1:0]       cfg_reg;
    logic [LW-1:0]          cap_lg_reg, cap_lg_next;
    logic [IW:0]            count_reg, count_next;
    logic [IW:0]            n_reg, n_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   put_reg, put_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [HW-1:0]          hash_reg, hash_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [EW-1:0]          mv_reg, mv_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_PORT_W-1:0] rv_reg, rv_next;

    logic          b_we [2];
    logic          b_re [2];
    logic [IW-1:0] b_waddr [2];
    logic [IW-1:0] b_raddr [2];
    logic [EW-1:0] b_wdata [2];
    logic [EW-1:0] b_rdata [2];

    logic [IW:0]            cap, newcap;
    logic [IW-1:0]          mask, newmask;
    logic [EW-1:0]          rd_old, rd_new;
    logic                   e_valid;
    logic [HW-1:0]          e_hash;
    logic [KEY_WIDTH-1:0]   e_key;
    logic [VALUE_WIDTH-1:0] e_val;
    logic                   hit, empty, last, out_free;
    logic [IW:0]            count_inc;
    logic [31:0]            load_lhs, load_rhs;

    lph_ram #(.WIDTH(EW), .AW(IW)) u_bank0 (
        .clk   (clk),
        .we    (b_we[0]),
        .waddr (b_waddr[0]),
        .wdata (b_wdata[0]),
        .re    (b_re[0]),
        .raddr (b_raddr[0]),
        .rdata (b_rdata[0])
    );

    lph_ram #(.WIDTH(EW), .AW(IW)) u_bank1 (
        .clk   (clk),
        .we    (b_we[1]),
        .waddr (b_waddr[1]),
        .wdata (b_wdata[1]),
        .re    (b_re[1]),
        .raddr (b_raddr[1]),
        .rdata (b_rdata[1])
    );

    assign cap       = (IW+1)'(1) << cap_lg_reg;
    assign newcap    = cap << 1;
    assign mask      = IW'(cap - (IW+1)'(1));
    assign newmask   = IW'(newcap - (IW+1)'(1));
    assign rd_old    = b_rdata[act_reg];
    assign rd_new    = b_rdata[~act_reg];
    assign e_valid   = rd_old[EW-1];
    assign e_hash    = rd_old[EW-2 -: HW];
    assign e_key     = rd_old[KEY_WIDTH+VALUE_WIDTH-1 -: KEY_WIDTH];
    assign e_val     = rd_old[VALUE_WIDTH-1:0];
    assign hit       = e_valid && (e_key == key_reg);
    assign empty     = !e_valid;
    assign last      = (n_reg + (IW+1)'(1)) == cap;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign count_inc = count_reg + (IW+1)'(1);
    assign load_lhs  = 32'(count_inc) * LOAD_SCALE;
    assign load_rhs  = 32'(cap) * 32'(LOAD_FACTOR_PERCENT);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.read_value = rv_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        cap_lg_next    = cap_lg_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        put_next       = put_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        val_next       = val_reg;
        mv_next        = mv_reg;
        status_next    = status_reg;
        rv_next        = rv_reg;
        for (int b = 0; b < 2; b++)
        begin
            b_we[b]    = 1'b0;
            b_re[b]    = 1'b0;
            b_waddr[b] = '0;
            b_raddr[b] = '0;
            b_wdata[b] = '0;
        end

        case (state_reg)
            S_CLR:
            begin
                b_we[act_reg]    = 1'b1;
                b_waddr[act_reg] = n_reg[IW-1:0];
                if (last)
                begin
                    n_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    n_next = n_reg + (IW+1)'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    put_next         = req.req_type;
                    key_next         = req.key[KEY_WIDTH-1:0];
                    hash_next        = req.key_hash[HW-1:0];
                    val_next         = req.put_value[VALUE_WIDTH-1:0];
                    idx_next         = req.key_hash[IW-1:0] & mask;
                    b_re[act_reg]    = 1'b1;
                    b_raddr[act_reg] = req.key_hash[IW-1:0] & mask;
                    n_next           = '0;
                    state_next       = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!(hit || empty || last))
                begin
                    idx_next         = (idx_reg + IW'(1)) & mask;
                    n_next           = n_reg + (IW+1)'(1);
                    b_re[act_reg]    = 1'b1;
                    b_raddr[act_reg] = (idx_reg + IW'(1)) & mask;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rv_next        = '0;
                    state_next     = S_IDLE;
                    if (put_reg == REQ_GET)
                    begin
                        status_next = hit ? ST_HIT : ST_MISS;
                        rv_next     = hit ? VALUE_PORT_W'(e_val) : '0;
                    end
                    else if (hit)
                    begin
                        b_we[act_reg]    = 1'b1;
                        b_waddr[act_reg] = idx_reg;
                        b_wdata[act_reg] = {rd_old[EW-1:VALUE_WIDTH], val_reg};
                        status_next      = ST_UPDATED;
                    end
                    else if (!empty || (cap_lg_reg == LW'(MAX_CAPACITY_LOG2)
                                        && count_inc >= cap))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        b_we[act_reg]    = 1'b1;
                        b_waddr[act_reg] = idx_reg;
                        b_wdata[act_reg] = {1'b1, hash_reg, key_reg, val_reg};
                        count_next       = count_inc;
                        status_next      = ST_INSERTED;
                        if (cap_lg_reg < LW'(MAX_CAPACITY_LOG2) && load_lhs > load_rhs)
                        begin
                            n_next     = '0;
                            state_next = S_GCLR;
                        end
                    end
                end
            end
            S_GCLR:
            begin
                b_we[~act_reg]    = 1'b1;
                b_waddr[~act_reg] = n_reg[IW-1:0];
                if ((n_reg + (IW+1)'(1)) == newcap)
                begin
                    n_next     = '0;
                    state_next = S_GRD;
                end
                else
                begin
                    n_next = n_reg + (IW+1)'(1);
                end
            end
            S_GRD:
            begin
                b_re[act_reg]    = 1'b1;
                b_raddr[act_reg] = n_reg[IW-1:0];
                state_next       = S_GCHK;
            end
            S_GCHK:
            begin
                if (e_valid)
                begin
                    mv_next           = rd_old;
                    idx_next          = e_hash[IW-1:0] & newmask;
                    b_re[~act_reg]    = 1'b1;
                    b_raddr[~act_reg] = e_hash[IW-1:0] & newmask;
                    state_next        = S_GPRB;
                end
                else if (last)
                begin
                    act_next    = ~act_reg;
                    cap_lg_next = cap_lg_reg + LW'(1);
                    n_next      = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    n_next     = n_reg + (IW+1)'(1);
                    state_next = S_GRD;
                end
            end
            S_GPRB:
            begin
                if (!rd_new[EW-1])
                begin
                    b_we[~act_reg]    = 1'b1;
                    b_waddr[~act_reg] = idx_reg;
                    b_wdata[~act_reg] = mv_reg;
                    if (last)
                    begin
                        act_next    = ~act_reg;
                        cap_lg_next = cap_lg_reg + LW'(1);
                        n_next      = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        n_next     = n_reg + (IW+1)'(1);
                        state_next = S_GRD;
                    end
                end
                else
                begin
                    idx_next          = (idx_reg + IW'(1)) & newmask;
                    b_re[~act_reg]    = 1'b1;
                    b_raddr[~act_reg] = (idx_reg + IW'(1)) & newmask;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            cap_lg_next = start_lg(cfg_wdata);
            count_next  = '0;
            n_next      = '0;
            state_next  = S_CLR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            act_reg       <= 1'b0;
            cfg_reg       <= CFG_RESET;
            cap_lg_reg    <= start_lg(CFG_RESET);
            count_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            cap_lg_reg    <= cap_lg_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        put_reg    <= put_next;
        key_reg    <= key_next;
        hash_reg   <= hash_next;
        val_reg    <= val_next;
        mv_reg     <= mv_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
    end

    `LPH_ASSERT_NOW(a_count_in_cap, 1'b1, count_reg <= cap, "Entry count exceeds capacity.")
    `LPH_ASSERT_NOW(a_no_accept_clear,
        state_reg == S_CLR || state_reg == S_GCLR || state_reg == S_GPRB, !req.ready,
        "Word accepted while clearing or rehashing.")
    `LPH_ASSERT_NEXT(a_accept_probe,
        req.valid && req.ready && !cfg_we, state_reg == S_PROBE,
        "Accepted word did not start a probe.")
    `LPH_ASSERT_NOW(a_cfg_matches,
        state_reg == S_IDLE, cap_lg_reg >= start_lg(cfg_reg),
        "Capacity below its configured start.")

endmodule

/* sv/lph_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sim/linear_probe_hash_map_test.sv */
// Self-checking testbench for the linear probing hash map with a local table predictor.
`timescale 1ns / 1ps

module linear_probe_hash_map_test;
    import lph_pkg::*;

    localparam int MAX_LG   = 10;
    localparam int MIN_LG   = 3;
    localparam int SLOTS    = 1 << MAX_LG;
    localparam int LOAD_PCT = 75;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [VALUE_PORT_W-1:0] read_value;
    } lookup_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lph_req_if req ();
    lph_rsp_if rsp ();

    linear_probe_hash_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    logic                    tbl_valid [SLOTS];
    logic [KEY_PORT_W-1:0]   tbl_key   [SLOTS];
    logic [HASH_PORT_W-1:0]  tbl_hash  [SLOTS];
    logic [VALUE_PORT_W-1:0] tbl_value [SLOTS];
    logic                    new_valid [SLOTS];
    logic [KEY_PORT_W-1:0]   new_key   [SLOTS];
    logic [HASH_PORT_W-1:0]  new_hash  [SLOTS];
    logic [VALUE_PORT_W-1:0] new_value [SLOTS];
    int unsigned cap_lg;
    int unsigned entries;
    int unsigned init_lg;

    lookup_result_t pending_results[$];
    logic [KEY_PORT_W-1:0] known_keys[$];
    int errors;
    int idle_cycles;
    int send_gap_pct;
    int recv_stall_pct;

    always #10 clk = ~clk;

    function automatic void clear_table(input logic [CFG_W-1:0] lg_reg);
        int unsigned lg;
        lg = 32'(lg_reg);
        if (lg < MIN_LG) lg = MIN_LG;
        if (lg > MAX_LG) lg = MAX_LG;
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        cap_lg = lg;
        entries = 0;
    endfunction

    function automatic void grow_table();
        int unsigned oldcap;
        int unsigned newcap;
        int unsigned idx;
        oldcap = 1 << cap_lg;
        newcap = oldcap << 1;
        for (int i = 0; i < SLOTS; i++) new_valid[i] = 1'b0;
        for (int i = 0; i < oldcap; i++) begin
            if (tbl_valid[i])
            begin
                idx = tbl_hash[i] & (newcap - 1);
                for (int n = 0; n < newcap && new_valid[idx]; n++) idx = (idx + 1) & (newcap - 1);
                new_valid[idx] = 1'b1;
                new_key[idx] = tbl_key[i];
                new_hash[idx] = tbl_hash[i];
                new_value[idx] = tbl_value[i];
            end
        end
        tbl_valid = new_valid;
        tbl_key = new_key;
        tbl_hash = new_hash;
        tbl_value = new_value;
        cap_lg++;
    endfunction

    function automatic lookup_result_t apply_request(input logic is_put,
            input logic [KEY_PORT_W-1:0] k, input logic [HASH_PORT_W-1:0] h,
            input logic [VALUE_PORT_W-1:0] v);
        lookup_result_t r;
        int unsigned cap;
        int unsigned idx;
        bit found;
        bit empty;
        cap = 1 << cap_lg;
        idx = h & (cap - 1);
        found = 0;
        empty = 0;
        r = '0;
        for (int n = 0; n < cap; n++) begin
            if (!tbl_valid[idx])
            begin
                empty = 1;
                break;
            end
            if (tbl_key[idx] == k)
            begin
                found = 1;
                break;
            end
            idx = (idx + 1) & (cap - 1);
        end
        if (is_put == REQ_GET)
        begin
            if (found)
            begin
                r.status = ST_HIT;
                r.read_value = tbl_value[idx];
            end
            else r.status = ST_MISS;
        end
        else if (found)
        begin
            tbl_value[idx] = v;
            r.status = ST_UPDATED;
        end
        else if (!empty || (cap_lg >= MAX_LG && entries + 1 >= cap))
            r.status = ST_FULL;
        else
        begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx] = k;
            tbl_hash[idx] = h;
            tbl_value[idx] = v;
            entries++;
            r.status = ST_INSERTED;
            if (cap_lg < MAX_LG && entries * 100 > cap * LOAD_PCT) grow_table();
        end
        return r;
    endfunction

    task automatic send_word(input logic is_put, input logic [KEY_PORT_W-1:0] k,
            input logic [HASH_PORT_W-1:0] h, input logic [VALUE_PORT_W-1:0] v);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= is_put;
        req.key <= k;
        req.key_hash <= h;
        req.put_value <= v;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pending_results.push_back(apply_request(is_put, k, h, v));
        if (is_put == REQ_PUT) known_keys.push_back(k);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] lg);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_we <= 1'b0;
        clear_table(lg);
        known_keys.delete();
    endtask

    task automatic send_random(input int count, input int hash_bits);
        logic [KEY_PORT_W-1:0] k;
        logic [HASH_PORT_W-1:0] h;
        for (int i = 0; i < count; i++) begin
            if (known_keys.size() != 0 && $urandom_range(2) == 0)
                k = known_keys[$urandom_range(known_keys.size() - 1)];
            else
                k = {$urandom, $urandom};
            h = $urandom;
            if ($urandom_range(3) != 0) h = h & ((32'd1 << hash_bits) - 1);
            send_word(1'($urandom_range(1)), k, h, {$urandom, $urandom});
        end
    endtask

    task automatic test_directed_extremes();
        send_word(REQ_GET, '0, '0, '0);
        send_word(REQ_PUT, '0, '0, '1);
        send_word(REQ_GET, '0, '1, '0);
        send_word(REQ_PUT, '1, '1, '0);
        send_word(REQ_GET, '1, 32'h7, '0);
        send_word(REQ_PUT, '1, '0, 64'h5555_aaaa_5555_aaaa);
        send_word(REQ_GET, '1, '1, '0);
        for (int i = 0; i < 8; i++)
            send_word(REQ_PUT, 64'h100 + i, 32'h3, {$urandom, $urandom});
        for (int i = 0; i < 8; i++)
            send_word(REQ_GET, 64'h100 + i, 32'h3, '0);
    endtask

    task automatic test_full_table();
        write_capacity(4'd10);
        send_gap_pct = 0;
        for (int i = 0; i < SLOTS + 1; i++)
            send_word(REQ_PUT, 64'h1000 + i, HASH_PORT_W'(i * 7), VALUE_PORT_W'(i));
        send_word(REQ_PUT, 64'h1005, 32'h0, '1);
        send_word(REQ_GET, 64'h1005, 32'h0, '0);
        send_word(REQ_GET, 64'hdead, 32'h0, '0);
    endtask

    always @(posedge clk) begin
        if (rst_n)
        begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected word: status %0d", rsp.status);
                end
                else
                begin
                    lookup_result_t e;
                    e = pending_results.pop_front();
                    if (e.status !== rsp.status || e.read_value !== rsp.read_value)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("expected %0d/%h actual %0d/%h", e.status,
                                e.read_value, rsp.status, rsp.read_value);
                    end
                end
            end
            if (idle_cycles > WATCHDOG)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.req_type = REQ_GET;
        req.key = '0;
        req.key_hash = '0;
        req.put_value = '0;
        rsp.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_gap_pct = 6;
        recv_stall_pct = 58;
        clear_table(CFG_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        send_random(200, 4);
        write_capacity(4'd0);
        send_gap_pct = 58;
        recv_stall_pct = 6;
        send_random(150, 6);
        write_capacity(4'd15);
        send_random(50, 10);
        write_capacity(4'd5);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        send_random(150, 8);
        test_full_table();
        drain_results();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/lph_pkg.sv
sv/lph_req_if.sv
sv/lph_rsp_if.sv
sv/lph_ram.sv
sv/linear_probe_hash_map.sv
sim/linear_probe_hash_map_test.sv
